[hw/rtl/csrp_pkg.sv]
// Shared types and constants for the clock synthesizer register planner.
// Used by every module under hw/rtl; depends on nothing else.
package csrp_pkg;

  localparam int FreqW     = 28;
  localparam int XtalW     = 26;
  localparam int DivDendW  = 46;
  localparam int DivSorW   = 32;
  localparam int DivStepW  = 6;
  localparam int P1W       = 18;
  localparam int P2W       = 20;

  localparam logic [29:0] PLL_TARGET     = 30'd900000000;
  localparam logic [19:0] FRAC_DENOM     = 20'hFFFFF;
  localparam logic [7:0]  PLL_RESET_BYTE = 8'hA0;
  localparam logic [P1W-1:0] P1_OFFSET   = 18'd512;

  localparam logic [XtalW-1:0] XTAL_RST  = 26'd25000000;
  localparam logic [7:0] PLL_BASE_RST    = 8'd26;
  localparam logic [7:0] MS_BASE_RST     = 8'd42;
  localparam logic [7:0] PLL_RESET_RST   = 8'd177;
  localparam logic [7:0] CLK0_REG_RST    = 8'd16;
  localparam logic [7:0] CLK0_VAL_RST    = 8'd79;
  localparam logic [6:0] R_DIV_RST       = 7'd0;

  localparam logic [DivStepW-1:0] STEPS_DIV1 = 6'd30;
  localparam logic [DivStepW-1:0] STEPS_DIV2 = 6'd32;
  localparam logic [DivStepW-1:0] STEPS_DIV3 = 6'd46;

  localparam logic [4:0] LAST_WRITE = 5'd17;

  typedef enum logic [2:0] {
    REG_XO_HZ          = 3'd0,
    REG_PLL_REG_BASE   = 3'd1,
    REG_MS_REG_BASE    = 3'd2,
    REG_PLL_RESET_REG  = 3'd3,
    REG_CLK0_CTRL_REG  = 3'd4,
    REG_CLK0_CTRL_VAL  = 3'd5,
    REG_R_DIV_BITS     = 3'd6
  } cfg_index_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_DIV1,
    F_MUL,
    F_DIV2,
    F_DIV3,
    F_PUSH
  } front_state_t;

  typedef struct packed {
    logic [XtalW-1:0] xo_hz;
    logic [7:0]       pll_reg_base;
    logic [7:0]       ms_reg_base;
    logic [7:0]       pll_reset_reg;
    logic [7:0]       clk0_ctrl_reg;
    logic [7:0]       clk0_ctrl_value;
    logic [6:0]       r_div_bits;
  } cfg_t;

  typedef struct packed {
    logic                start;
    logic [DivDendW-1:0] dividend;
    logic [DivSorW-1:0]  divisor;
    logic [DivStepW-1:0] steps;
  } div_cmd_t;

  typedef struct packed {
    logic [P1W-1:0] p1_pll;
    logic [P2W-1:0] p2_pll;
    logic [P1W-1:0] p1_ms;
  } plan_t;

endpackage

[hw/rtl/csrp_div.sv]
// Restoring divider, one quotient bit per cycle, dividend left-aligned.
// Depends on csrp_pkg.
module csrp_div import csrp_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  div_cmd_t            cmd,
  output logic                done,
  output logic [DivDendW-1:0] quotient,
  output logic [DivSorW-1:0]  remainder
);

  logic [DivSorW:0]     rem;
  logic [DivDendW-1:0]  sr;
  logic [DivSorW-1:0]   divisor;
  logic [DivStepW-1:0]  cnt;
  logic                 run;
  logic [DivSorW:0]     rem_sh;
  logic                 fits;

  assign rem_sh = {rem[DivSorW-1:0], sr[DivDendW-1]};
  assign fits   = rem_sh >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= run && (cnt == 6'd1);
      if (cmd.start) begin
        run <= 1'b1;
        cnt <= cmd.steps;
      end else if (run) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) run <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      rem     <= '0;
      sr      <= cmd.dividend;
      divisor <= cmd.divisor;
    end else if (run) begin
      rem <= fits ? (rem_sh - {1'b0, divisor}) : rem_sh;
      sr  <= {sr[DivDendW-2:0], fits};
    end
  end

  assign quotient  = sr;
  assign remainder = rem[DivSorW-1:0];

endmodule

[hw/rtl/csrp_front.sv]
// Front end: takes a frequency and works out the divider and PLL parameters.
// Depends on csrp_pkg and csrp_div.
module csrp_front import csrp_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [FreqW-1:0] frequency,
  output logic             busy,
  input  logic [XtalW-1:0] xo_hz,
  input  logic             q_full,
  output logic             push,
  output plan_t            plan
);

  front_state_t state, state_next;
  logic             in_full;
  logic [FreqW-1:0] in_freq;
  logic [FreqW-1:0] freq;
  logic [29:0]      divider;
  logic [7:0]       mult;
  logic [19:0]      num;
  logic             take;

  div_cmd_t             cmd;
  logic                 div_done;
  logic [DivDendW-1:0]  quot;
  logic [DivSorW-1:0]   drem;

  logic                 xtal_zero;
  logic [25:0]          rem_eff;
  logic [31:0]          pll;
  logic [26:0]          x;
  logic [6:0]           fq;
  logic [20:0]          fr;
  logic                 corr;
  logic [6:0]           frac;

  csrp_div u_div (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .done      (div_done),
    .quotient  (quot),
    .remainder (drem)
  );

  assign busy      = in_full;
  assign xtal_zero = (xo_hz == '0);
  assign rem_eff   = xtal_zero ? 26'd0 : drem[25:0];
  assign pll       = 32'({2'b0, divider} * {4'b0, freq});

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= F_IDLE;
      in_full <= 1'b0;
    end else begin
      state <= state_next;
      if (start && !in_full) in_full <= 1'b1;
      else if (take) in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !in_full) in_freq <= frequency;
    if (take) freq <= in_freq;
    if (state == F_DIV1 && div_done) begin
      divider <= (freq == '0) ? 30'd0 : {quot[29:1], 1'b0};
    end
    if (state == F_DIV2 && div_done) mult <= xtal_zero ? 8'd0 : quot[7:0];
    if (state == F_DIV3 && div_done) num <= xtal_zero ? 20'd0 : quot[19:0];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      F_IDLE: if (in_full) state_next = F_DIV1;
      F_DIV1: if (div_done) state_next = F_MUL;
      F_MUL:  state_next = F_DIV2;
      F_DIV2: if (div_done) state_next = F_DIV3;
      F_DIV3: if (div_done) state_next = F_PUSH;
      F_PUSH: if (!q_full) state_next = F_IDLE;
      default: state_next = F_IDLE;
    endcase
  end

  always_comb begin
    take      = 1'b0;
    push      = 1'b0;
    cmd.start = 1'b0;
    cmd.dividend = '0;
    cmd.divisor  = '0;
    cmd.steps    = '0;
    unique case (state)
      F_IDLE: begin
        take         = in_full;
        cmd.start    = in_full;
        cmd.dividend = {PLL_TARGET, 16'b0};
        cmd.divisor  = {4'b0, in_freq};
        cmd.steps    = STEPS_DIV1;
      end
      F_MUL: begin
        cmd.start    = 1'b1;
        cmd.dividend = {pll, 14'b0};
        cmd.divisor  = {6'b0, xo_hz};
        cmd.steps    = STEPS_DIV2;
      end
      F_DIV2: begin
        // remainder times the fixed denominator, as (rem << 20) - rem
        cmd.start    = div_done;
        cmd.dividend = {rem_eff, 20'b0} - {20'b0, rem_eff};
        cmd.divisor  = {6'b0, xo_hz};
        cmd.steps    = STEPS_DIV3;
      end
      F_PUSH: push = !q_full;
      default: ;
    endcase
  end

  // divide 128*num by 2^20-1: quotient estimate plus one correction
  assign x    = {num, 7'b0};
  assign fq   = x[26:20];
  assign fr   = {1'b0, x[19:0]} + {14'b0, fq};
  assign corr = fr >= {1'b0, FRAC_DENOM};
  assign frac = fq + {6'b0, corr};

  always_comb begin
    plan.p1_pll = {3'b0, mult, 7'b0} + {11'b0, frac} - P1_OFFSET;
    plan.p2_pll = corr ? 20'(fr - {1'b0, FRAC_DENOM}) : fr[19:0];
    plan.p1_ms  = {divider[10:0], 7'b0} - P1_OFFSET;
  end

endmodule

[hw/rtl/csrp_fifo.sv]
// Two-entry queue of computed plans between front and back end.
// Depends on csrp_pkg.
module csrp_fifo import csrp_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  plan_t wdata,
  input  logic  pop,
  output plan_t rdata,
  output logic  full,
  output logic  nonempty
);

  plan_t       mem [2];
  logic        wptr;
  logic        rptr;
  logic [1:0]  count;

  assign full     = (count == 2'd2);
  assign nonempty = (count != 2'd0);
  assign rdata    = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= wdata;
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> nonempty)
    else $error("pop from empty queue");
`endif

endmodule

[hw/rtl/csrp_back.sv]
// Back end: turns one plan into eighteen register writes, one per cycle.
// Depends on csrp_pkg.
module csrp_back import csrp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        q_nonempty,
  input  plan_t       q_data,
  output logic        pop,
  output logic        strobe,
  output logic [7:0]  reg_addr,
  output logic [7:0]  reg_data,
  output logic        last
);

  plan_t       entry;
  logic        active;
  logic [4:0]  idx;
  logic [7:0]  addr_c;
  logic [7:0]  data_c;

  assign pop = q_nonempty && (!active || idx == LAST_WRITE);

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      idx    <= '0;
      strobe <= 1'b0;
      last   <= 1'b0;
    end else begin
      strobe <= active;
      last   <= active && (idx == LAST_WRITE);
      if (pop) begin
        active <= 1'b1;
        idx    <= '0;
      end else if (active) begin
        if (idx == LAST_WRITE) active <= 1'b0;
        else idx <= idx + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) entry <= q_data;
    reg_addr <= addr_c;
    reg_data <= data_c;
  end

  always_comb begin
    addr_c = 8'd0;
    data_c = 8'd0;
    if (idx[4]) begin
      if (idx[0]) begin
        addr_c = cfg.clk0_ctrl_reg;
        data_c = cfg.clk0_ctrl_value;
      end else begin
        addr_c = cfg.pll_reset_reg;
        data_c = PLL_RESET_BYTE;
      end
    end else if (!idx[3]) begin
      addr_c = cfg.pll_reg_base + {5'b0, idx[2:0]};
      case (idx[2:0])
        3'd0: data_c = 8'hFF;
        3'd1: data_c = 8'hFF;
        3'd2: data_c = {6'b0, entry.p1_pll[17:16]};
        3'd3: data_c = entry.p1_pll[15:8];
        3'd4: data_c = entry.p1_pll[7:0];
        3'd5: data_c = {4'hF, entry.p2_pll[19:16]};
        3'd6: data_c = entry.p2_pll[15:8];
        default: data_c = entry.p2_pll[7:0];
      endcase
    end else begin
      addr_c = cfg.ms_reg_base + {5'b0, idx[2:0]};
      case (idx[2:0])
        3'd1: data_c = 8'd1;
        3'd2: data_c = {1'b0, cfg.r_div_bits} | {6'b0, entry.p1_ms[17:16]};
        3'd3: data_c = entry.p1_ms[15:8];
        3'd4: data_c = entry.p1_ms[7:0];
        default: data_c = 8'd0;
      endcase
    end
  end

`ifndef SYNTH
  a_last_strobed: assert property (@(posedge clk) disable iff (rst) last |-> strobe)
    else $error("last without strobe");
  a_run_unbroken: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |=> strobe)
    else $error("write run broken before last");
`endif

endmodule

[hw/rtl/clock_synth_register_planner.sv]
// Clock synthesizer register planner: top level with configuration registers.
// Depends on csrp_pkg, csrp_front, csrp_fifo and csrp_back.
//
// A frequency is taken when start is high and busy is low; the block then
// emits eighteen register writes, one per clock, each marked by strobe, with
// last on the eighteenth. The receiver cannot stall the writes. The front end
// works out the parameters on one shared bit-serial divider, in three divisions
// of 30, 32 and 46 steps that set the sustained rate; the write sequence
// overlaps with the next computation through a two-entry plan queue.
// Configuration is written through wr_en/wr_index/wr_data with no wait.
module clock_synth_register_planner import csrp_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic [FreqW-1:0] frequency,
  input  logic             wr_en,
  input  logic [2:0]       wr_index,
  input  logic [XtalW-1:0] wr_data,
  output logic             strobe,
  output logic [7:0]       reg_addr,
  output logic [7:0]       reg_data,
  output logic             last
);

  cfg_t  cfg;
  plan_t plan;
  plan_t q_data;
  logic  push;
  logic  pop;
  logic  q_full;
  logic  q_nonempty;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.xo_hz           <= XTAL_RST;
      cfg.pll_reg_base    <= PLL_BASE_RST;
      cfg.ms_reg_base     <= MS_BASE_RST;
      cfg.pll_reset_reg   <= PLL_RESET_RST;
      cfg.clk0_ctrl_reg   <= CLK0_REG_RST;
      cfg.clk0_ctrl_value <= CLK0_VAL_RST;
      cfg.r_div_bits      <= R_DIV_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_XO_HZ:         cfg.xo_hz           <= wr_data;
        REG_PLL_REG_BASE:  cfg.pll_reg_base    <= wr_data[7:0];
        REG_MS_REG_BASE:   cfg.ms_reg_base     <= wr_data[7:0];
        REG_PLL_RESET_REG: cfg.pll_reset_reg   <= wr_data[7:0];
        REG_CLK0_CTRL_REG: cfg.clk0_ctrl_reg   <= wr_data[7:0];
        REG_CLK0_CTRL_VAL: cfg.clk0_ctrl_value <= wr_data[7:0];
        REG_R_DIV_BITS:    cfg.r_div_bits      <= wr_data[6:0];
        default: ;
      endcase
    end
  end

  csrp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .frequency (frequency),
    .busy      (busy),
    .xo_hz     (cfg.xo_hz),
    .q_full    (q_full),
    .push      (push),
    .plan      (plan)
  );

  csrp_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wdata    (plan),
    .pop      (pop),
    .rdata    (q_data),
    .full     (q_full),
    .nonempty (q_nonempty)
  );

  csrp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .q_nonempty (q_nonempty),
    .q_data     (q_data),
    .pop        (pop),
    .strobe     (strobe),
    .reg_addr   (reg_addr),
    .reg_data   (reg_data),
    .last       (last)
  );

endmodule
